### rtl/gsl_pkg.sv
// gsl_pkg: widths, reset values, register map and shared types of the gripper stall lock
// no dependencies; used by the channel interfaces, gsl_lock_core and gripper_stall_lock

package gsl_pkg;

    localparam int POS_BITS   = 24;
    localparam int THR_BITS   = 23;
    localparam int TICK_BITS  = 16;
    localparam int GAIN_BITS  = 32;
    localparam int MOTOR_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int ADDR_BITS  = 5;
    localparam int DATA_BITS  = 32;

    // compare width holds a position difference and any threshold as signed values
    localparam int CMP_BITS  = (POS_BITS + 1 > THR_BITS + 1) ? POS_BITS + 1 : THR_BITS + 1;
    localparam int PROD_BITS = POS_BITS + GAIN_BITS;
    localparam int RND_BITS  = PROD_BITS + 1;
    localparam int QUOT_BITS = RND_BITS - FRAC_BITS;

    typedef logic signed [POS_BITS-1:0]   pos_t;
    typedef logic        [THR_BITS-1:0]   thr_t;
    typedef logic        [TICK_BITS-1:0]  tick_t;
    typedef logic signed [GAIN_BITS-1:0]  gain_t;
    typedef logic signed [MOTOR_BITS-1:0] motor_t;
    typedef logic signed [CMP_BITS-1:0]   cmp_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [RND_BITS-1:0]   rnd_t;
    typedef logic signed [QUOT_BITS-1:0]  quot_t;

    localparam thr_t  ERROR_THR_RST   = THR_BITS'(2000);
    localparam thr_t  MOTION_THR_RST  = THR_BITS'(100);
    localparam thr_t  RELEASE_THR_RST = THR_BITS'(5000);
    localparam tick_t STALL_TICKS_RST = TICK_BITS'(50);
    localparam gain_t MOTOR_GAIN_RST  = -GAIN_BITS'(1559757);

    localparam tick_t TICK_MAX = {TICK_BITS{1'b1}};
    localparam rnd_t  RND_HALF = RND_BITS'(1) <<< (FRAC_BITS - 1);
    localparam motor_t MOTOR_MAX = {1'b0, {(MOTOR_BITS-1){1'b1}}};
    localparam motor_t MOTOR_MIN = {1'b1, {(MOTOR_BITS-1){1'b0}}};

    // register index, taken from paddr word address
    typedef enum logic [2:0] {
        REG_ERROR_THR   = 3'd0,
        REG_MOTION_THR  = 3'd1,
        REG_RELEASE_THR = 3'd2,
        REG_STALL_TICKS = 3'd3,
        REG_MOTOR_GAIN  = 3'd4
    } gsl_reg_t;

    typedef struct packed {
        thr_t  error_thr;
        thr_t  motion_thr;
        thr_t  release_thr;
        tick_t stall_ticks;
        gain_t motor_gain;
    } gsl_cfg_t;

    // per-beat outcome of the lock decision
    typedef struct packed {
        pos_t held;
        logic lock;
    } gsl_decision_t;

    // lock state as it stands before the current beat
    typedef struct packed {
        logic locked;
        pos_t position;
    } gsl_lock_state_t;

    // round half toward plus infinity, floor by 2^FRAC_BITS, saturate to motor range
    function automatic motor_t round_sat(prod_t prod);
        rnd_t  sum;
        quot_t quot;
        logic  fits;
        sum  = rnd_t'(prod) + RND_HALF;
        quot = quot_t'(sum >>> FRAC_BITS);
        fits = (&quot[QUOT_BITS-1:MOTOR_BITS-1]) | ~(|quot[QUOT_BITS-1:MOTOR_BITS-1]);
        if (fits)
            return motor_t'(quot[MOTOR_BITS-1:0]);
        else if (quot[QUOT_BITS-1])
            return MOTOR_MIN;
        else
            return MOTOR_MAX;
    endfunction

endpackage

### rtl/gsl_sample_if.sv
// gsl_sample_if: input channel of the gripper stall lock, one beat per control tick
// depends on gsl_pkg

interface gsl_sample_if import gsl_pkg::*; ();

    logic valid;
    logic ready;
    pos_t commanded_pos;
    pos_t measured_pos;

    modport source (output valid, commanded_pos, measured_pos, input ready);
    modport sink   (input valid, commanded_pos, measured_pos, output ready);

endinterface

### rtl/gsl_result_if.sv
// gsl_result_if: result channel of the gripper stall lock, one beat per input beat
// depends on gsl_pkg

interface gsl_result_if import gsl_pkg::*; ();

    logic   valid;
    logic   ready;
    pos_t   held_command;
    motor_t motor_urad;
    logic   stall_locked;

    modport source (output valid, held_command, motor_urad, stall_locked, input ready);
    modport sink   (input valid, held_command, motor_urad, stall_locked, output ready);

endinterface

### rtl/gsl_lock_core.sv
// gsl_lock_core: stall counter, lock state and held-command decision for one beat
// depends on gsl_pkg

module gsl_lock_core import gsl_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  gsl_cfg_t        cfg,
    input  logic            fire,
    input  pos_t            cmd,
    input  pos_t            meas,
    output gsl_decision_t   res,
    output gsl_lock_state_t st
);

    logic  lock_reg;
    logic  lock_next;
    tick_t count_reg;
    tick_t count_next;
    pos_t  position_reg;
    pos_t  position_next;
    pos_t  prev_reg;

    cmp_t  rise;
    cmp_t  err;
    cmp_t  change;
    cmp_t  err_abs;
    cmp_t  change_abs;
    tick_t count_inc;
    logic  release_hit;
    logic  stalled;

    always_comb
    begin
        rise       = cmp_t'(cmd) - cmp_t'(position_reg);
        err        = cmp_t'(cmd) - cmp_t'(meas);
        change     = cmp_t'(meas) - cmp_t'(prev_reg);
        err_abs    = err[CMP_BITS-1] ? -err : err;
        change_abs = change[CMP_BITS-1] ? -change : change;
        count_inc  = (count_reg == TICK_MAX) ? count_reg : count_reg + TICK_BITS'(1);

        release_hit = rise > cmp_t'(cfg.release_thr);
        stalled     = (err_abs > cmp_t'(cfg.error_thr)) && (change_abs < cmp_t'(cfg.motion_thr));

        lock_next     = lock_reg;
        count_next    = count_reg;
        position_next = position_reg;
        res.held      = cmd;

        if (lock_reg)
        begin
            if (release_hit)
            begin
                lock_next  = 1'b0;
                count_next = '0;
            end
            else
            begin
                res.held = position_reg;
            end
        end
        else if (stalled)
        begin
            count_next = count_inc;
            if (count_inc >= cfg.stall_ticks)
            begin
                lock_next     = 1'b1;
                position_next = meas;
                res.held      = meas;
            end
        end
        else
        begin
            count_next = '0;
        end

        res.lock    = lock_next;
        st.locked   = lock_reg;
        st.position = position_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_reg     <= 1'b0;
            count_reg    <= '0;
            position_reg <= '0;
            prev_reg     <= '0;
        end
        else if (fire)
        begin
            lock_reg     <= lock_next;
            count_reg    <= count_next;
            position_reg <= position_next;
            prev_reg     <= meas;
        end
    end

endmodule

### rtl/gripper_stall_lock.sv
// gripper_stall_lock: top level, APB register file, input register and result register
// depends on gsl_pkg, gsl_sample_if, gsl_result_if and gsl_lock_core

// Takes one beat per control tick carrying the commanded and measured gripper
// position and returns one beat with the held command, the motor command and
// the lock flag. A new beat is taken in every cycle while the result side keeps
// up. A beat first lands in the input register; once the result register can take
// it, the lock decision (which also updates the stall counter and lock state), the
// 24 x 32 gain multiply and rounding plus saturation go in one pass into the
// result register, from which the result beat is offered. The state update
// happens as the beat leaves the input register, so consecutive beats see each
// other's effect with no gap. Both registers hold their beat while the result
// side stalls and bubbles close up; with the result side held off the block
// keeps two beats and then drops sample.ready, and throughput is one beat per
// cycle whenever result.ready stays high.
// Registers sit on an APB port at byte addresses 0, 4, 8, 12 and 16: error
// threshold, motion threshold, release threshold, stall tick count and the
// signed Q16 motor gain; write them only while no beat is in flight.

module gripper_stall_lock import gsl_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    gsl_sample_if.sink           sample,
    gsl_result_if.source         result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    // configuration registers
    thr_t     error_thr_reg;
    thr_t     motion_thr_reg;
    thr_t     release_thr_reg;
    tick_t    stall_ticks_reg;
    gain_t    motor_gain_reg;
    gsl_cfg_t cfg;
    gsl_reg_t reg_sel;
    logic     wr_en;

    // input and result registers
    logic   v1_reg;
    pos_t   cmd1_reg;
    pos_t   meas1_reg;
    logic   v2_reg;
    pos_t   held2_reg;
    logic   lock2_reg;
    motor_t motor2_reg;
    motor_t motor_next;

    logic rdy1;
    logic rdy2;
    logic load2;

    gsl_decision_t   res;
    gsl_lock_state_t st;

    // ---------------------------------------------------------------- APB port
    assign pready  = 1'b1;
    assign reg_sel = gsl_reg_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_thr_reg   <= ERROR_THR_RST;
            motion_thr_reg  <= MOTION_THR_RST;
            release_thr_reg <= RELEASE_THR_RST;
            stall_ticks_reg <= STALL_TICKS_RST;
            motor_gain_reg  <= MOTOR_GAIN_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_ERROR_THR:   error_thr_reg   <= pwdata[THR_BITS-1:0];
                REG_MOTION_THR:  motion_thr_reg  <= pwdata[THR_BITS-1:0];
                REG_RELEASE_THR: release_thr_reg <= pwdata[THR_BITS-1:0];
                REG_STALL_TICKS: stall_ticks_reg <= pwdata[TICK_BITS-1:0];
                REG_MOTOR_GAIN:  motor_gain_reg  <= gain_t'(pwdata[GAIN_BITS-1:0]);
                default: ;  // unmapped words ignore writes
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_ERROR_THR:   prdata = DATA_BITS'(error_thr_reg);
            REG_MOTION_THR:  prdata = DATA_BITS'(motion_thr_reg);
            REG_RELEASE_THR: prdata = DATA_BITS'(release_thr_reg);
            REG_STALL_TICKS: prdata = DATA_BITS'(stall_ticks_reg);
            REG_MOTOR_GAIN:  prdata = DATA_BITS'(unsigned'(motor_gain_reg));
            default:         prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.error_thr   = error_thr_reg;
        cfg.motion_thr  = motion_thr_reg;
        cfg.release_thr = release_thr_reg;
        cfg.stall_ticks = stall_ticks_reg;
        cfg.motor_gain  = motor_gain_reg;
    end

    // ------------------------------------------------------------ flow control
    // a register takes a new beat when it is empty or its beat moves on this cycle
    assign rdy2  = !v2_reg || result.ready;
    assign rdy1  = !v1_reg || rdy2;
    assign load2 = v1_reg && rdy2;

    assign sample.ready = rdy1;

    // --------------------------------------------------------- input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (rdy1)
            v1_reg <= sample.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && sample.valid)
        begin
            cmd1_reg  <= sample.commanded_pos;
            meas1_reg <= sample.measured_pos;
        end
    end

    // ------------------------------------- lock decision, multiply, rounding
    // lock state advances exactly once per beat, when the beat leaves the input register
    gsl_lock_core u_lock_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (load2),
        .cmd   (cmd1_reg),
        .meas  (meas1_reg),
        .res   (res),
        .st    (st)
    );

    // held command times the Q16 gain, rounded half up and saturated
    always_comb
    begin
        motor_next = round_sat(prod_t'(res.held) * prod_t'(cfg.motor_gain));
    end

    // -------------------------------------------------------- result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (rdy2)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            held2_reg  <= res.held;
            lock2_reg  <= res.lock;
            motor2_reg <= motor_next;
        end
    end

    assign result.valid        = v2_reg;
    assign result.held_command = held2_reg;
    assign result.motor_urad   = motor2_reg;
    assign result.stall_locked = lock2_reg;

    // --------------------------------------------------------------- checks
    // a beat that stays locked keeps the recorded position
    a_hold_position: assert property (@(posedge clk) disable iff (!rst_n)
        (load2 && st.locked && res.lock) |=> (held2_reg == $past(st.position)))
        else $error("locked beat did not hold the recorded position");

    // the beat that engages the lock holds its own measurement
    a_lock_on_meas: assert property (@(posedge clk) disable iff (!rst_n)
        (load2 && !st.locked && res.lock) |-> (res.held == meas1_reg))
        else $error("lock engaged on a position other than the measurement");

    // a stalled result register keeps its beat
    a_result_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !result.ready) |=> (v2_reg && $stable(motor2_reg) && $stable(held2_reg)))
        else $error("result register lost a stalled beat");

endmodule

### test/tb.sv
// tb: self-checking bench for gripper_stall_lock, a directed table then random stall episodes
// depends on gsl_pkg, gsl_sample_if, gsl_result_if and the gripper_stall_lock rtl

module tb;
    import gsl_pkg::*;

    // position range of one beat field
    localparam longint POS_MAX = (longint'(1) <<< (POS_BITS - 1)) - 1;
    localparam longint POS_MIN = -(longint'(1) <<< (POS_BITS - 1));
    localparam int NUM_PHASES       = 8;
    localparam int PHASE_ITEMS      = 170;
    localparam int DRAIN_CYCLES     = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int END_WAIT_LIMIT   = 20000;
    localparam int STALL_RUN_CAP    = 60;

    // one expected result beat
    typedef struct {
        pos_t   held;
        motor_t motor;
        logic   locked;
    } tick_result_t;

    // one row of the directed table: a register write or a sample beat
    typedef struct {
        bit                   is_cfg;
        gsl_reg_t             reg_idx;
        logic [DATA_BITS-1:0] value;
        pos_t                 cmd;
        pos_t                 meas;
        bit                   typed;
        tick_result_t         want;
    } plan_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    gsl_sample_if sample_ch ();
    gsl_result_if result_ch ();

    gripper_stall_lock i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // register shadow as the predictor sees it
    thr_t  cfg_error_thr   = ERROR_THR_RST;
    thr_t  cfg_motion_thr  = MOTION_THR_RST;
    thr_t  cfg_release_thr = RELEASE_THR_RST;
    tick_t cfg_stall_ticks = STALL_TICKS_RST;
    gain_t cfg_motor_gain  = MOTOR_GAIN_RST;

    // lock state of the predictor, reset values
    bit   lock_held = 1'b0;
    int   stall_run = 0;
    pos_t lock_pos  = '0;
    pos_t last_meas = '0;

    tick_result_t pending_ticks[$];
    plan_row_t    plan_rows[$];
    tick_result_t unused_want = '{held: '0, motor: '0, locked: 1'b0};

    int mismatch_count = 0;
    int beats_checked  = 0;
    int items_sent     = 0;
    bit no_idle        = 1'b0;
    bit long_hold_req  = 1'b0;

    // clock, period 10
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // one printed line per failure, and a count
    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("beat %0d %s: got %0d, expected %0d", beats_checked, what, got, want);
    endtask

    function automatic pos_t clamp_pos(input longint v);
        if (v > POS_MAX)
            return pos_t'(POS_MAX);
        if (v < POS_MIN)
            return pos_t'(POS_MIN);
        return pos_t'(v);
    endfunction

    // lock decision and motor scaling for one accepted sample beat
    function automatic tick_result_t predict_tick(input pos_t cmd, input pos_t meas);
        tick_result_t r;
        longint c;
        longint m;
        longint held_l;
        longint err;
        longint chg;
        longint prod;
        longint q;
        c = cmd;
        m = meas;
        held_l = c;
        if (lock_held)
        begin
            // release clears the count and passes the command straight through
            if (c - longint'(lock_pos) > longint'(cfg_release_thr))
            begin
                lock_held = 1'b0;
                stall_run = 0;
            end
            else
                held_l = lock_pos;
        end
        else
        begin
            err = (c > m) ? c - m : m - c;
            chg = m - longint'(last_meas);
            if (chg < 0)
                chg = -chg;
            if (err > longint'(cfg_error_thr) && chg < longint'(cfg_motion_thr))
            begin
                // count stops at the top of its range
                if (stall_run < 65535)
                    stall_run++;
                if (longint'(stall_run) >= longint'(cfg_stall_ticks))
                begin
                    lock_held = 1'b1;
                    lock_pos  = meas;
                    held_l    = m;
                end
            end
            else
                stall_run = 0;
        end
        last_meas = meas;
        // round half up, floor by 2^16, then saturate
        prod = held_l * longint'(cfg_motor_gain) + 32768;
        q = prod >>> FRAC_BITS;
        if (q > longint'(MOTOR_MAX))
            q = longint'(MOTOR_MAX);
        if (q < longint'(MOTOR_MIN))
            q = longint'(MOTOR_MIN);
        r.held   = pos_t'(held_l);
        r.motor  = motor_t'(q);
        r.locked = lock_held;
        return r;
    endfunction

    // offer one sample beat, with an optional idle burst before it
    task automatic send_tick(input pos_t cmd, input pos_t meas, input bit typed,
                             input tick_result_t typed_want);
        int gap;
        tick_result_t want;
        gap = 0;
        if (!no_idle && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 13);
        @(negedge clk);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid         <= 1'b1;
        sample_ch.commanded_pos <= cmd;
        sample_ch.measured_pos  <= meas;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        // beat taken at this edge
        want = predict_tick(cmd, meas);
        if (typed)
            want = typed_want;
        pending_ticks.insert(pending_ticks.size(), want);
        items_sent++;
    endtask

    // write one register once the pipeline is empty, then read it back
    task automatic write_reg(input gsl_reg_t idx, input logic [DATA_BITS-1:0] value);
        logic [DATA_BITS-1:0] want;
        logic [DATA_BITS-1:0] got;
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        while (pending_ticks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        // setup then access
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        // read back on the same address
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        want = '0;
        case (idx)
            REG_ERROR_THR:
            begin
                cfg_error_thr = value[THR_BITS-1:0];
                want = DATA_BITS'(cfg_error_thr);
            end
            REG_MOTION_THR:
            begin
                cfg_motion_thr = value[THR_BITS-1:0];
                want = DATA_BITS'(cfg_motion_thr);
            end
            REG_RELEASE_THR:
            begin
                cfg_release_thr = value[THR_BITS-1:0];
                want = DATA_BITS'(cfg_release_thr);
            end
            REG_STALL_TICKS:
            begin
                cfg_stall_ticks = value[TICK_BITS-1:0];
                want = DATA_BITS'(cfg_stall_ticks);
            end
            REG_MOTOR_GAIN:
            begin
                cfg_motor_gain = value;
                want = cfg_motor_gain;
            end
            default:
            begin
            end
        endcase
        if (got !== want)
            report_mismatch($sformatf("readback of register %s", idx.name()),
                            longint'(got), longint'(want));
    endtask

    // measurement nearly still, command far away
    task automatic send_stall_tick();
        longint d;
        longint e;
        pos_t m;
        pos_t c;
        d = 0;
        if (cfg_motion_thr != 0)
            d = $urandom_range(0, int'(cfg_motion_thr) - 1);
        if ($urandom_range(0, 1))
            d = -d;
        m = clamp_pos(longint'(last_meas) + d);
        e = longint'(cfg_error_thr) + 1 + $urandom_range(0, 1000);
        if ($urandom_range(0, 1))
            e = -e;
        c = clamp_pos(longint'(m) + e);
        send_tick(c, m, 1'b0, unused_want);
    endtask

    // one random episode: hold and release if locked, then a stall run, a broken run or noise
    task automatic run_episode();
        int kind;
        int cap;
        int len;
        longint below;
        longint above;
        longint jump;
        if (lock_held)
        begin
            repeat ($urandom_range(0, 5))
            begin
                below = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 2000);
                send_tick(clamp_pos(longint'(lock_pos) + longint'(cfg_release_thr) - below),
                          pos_t'($urandom()), 1'b0, unused_want);
            end
            // mostly one or two past the threshold, sometimes right on it
            above = $urandom_range(0, 2);
            send_tick(clamp_pos(longint'(lock_pos) + longint'(cfg_release_thr) + above),
                      clamp_pos(longint'(lock_pos) + $urandom_range(0, 20)), 1'b0, unused_want);
        end
        kind = $urandom_range(0, 9);
        cap = (int'(cfg_stall_ticks) > STALL_RUN_CAP) ? STALL_RUN_CAP : int'(cfg_stall_ticks);
        if (kind < 6)
        begin
            // well-formed run, long enough to lock unless the stall tick count exceeds the run cap
            len = cap + $urandom_range(0, 3);
            if (len == 0)
                len = 1;
            repeat (len) send_stall_tick();
        end
        else if (kind < 8)
        begin
            // run cut short by a move
            len = $urandom_range(1, (cap > 1) ? cap - 1 : 1);
            repeat (len) send_stall_tick();
            jump = longint'(cfg_motion_thr) + $urandom_range(0, 1000);
            if ($urandom_range(0, 1))
                jump = -jump;
            send_tick(pos_t'($urandom()), clamp_pos(longint'(last_meas) + jump),
                      1'b0, unused_want);
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                send_tick(pos_t'($urandom()), pos_t'($urandom()), 1'b0, unused_want);
        end
    endtask

    function automatic void add_cfg(input gsl_reg_t idx, input logic [DATA_BITS-1:0] value);
        plan_row_t row;
        row = '{reg_idx: REG_ERROR_THR, default: '0};
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.value   = value;
        plan_rows.insert(plan_rows.size(), row);
    endfunction

    function automatic void add_tick(input longint cmd, input longint meas);
        plan_row_t row;
        row = '{reg_idx: REG_ERROR_THR, default: '0};
        row.cmd  = pos_t'(cmd);
        row.meas = pos_t'(meas);
        plan_rows.insert(plan_rows.size(), row);
    endfunction

    function automatic void add_typed(input longint cmd, input longint meas, input longint held,
                                      input motor_t motor, input logic locked);
        plan_row_t row;
        row = '{reg_idx: REG_ERROR_THR, default: '0};
        row.cmd         = pos_t'(cmd);
        row.meas        = pos_t'(meas);
        row.typed       = 1'b1;
        row.want.held   = pos_t'(held);
        row.want.motor  = motor;
        row.want.locked = locked;
        plan_rows.insert(plan_rows.size(), row);
    endfunction

    // result side: random ready bursts, one long hold-off on request, none at the end
    initial
    begin : ready_driver
        int len;
        logic lvl;
        @(negedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                lvl = 1'b0;
                len = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            else if (no_idle)
            begin
                lvl = 1'b1;
                len = 1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                lvl = 1'b0;
                len = $urandom_range(1, 13);
            end
            else
            begin
                lvl = 1'b1;
                len = $urandom_range(1, 40);
            end
            result_ch.ready <= lvl;
            repeat (len) @(negedge clk);
        end
    end

    // compare every result beat with the oldest expectation
    always @(posedge clk)
    begin : result_check
        tick_result_t want;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (pending_ticks.size() == 0)
                report_mismatch("beat with nothing expected", longint'(result_ch.held_command), 0);
            else
            begin
                want = pending_ticks.pop_front();
                if (result_ch.held_command !== want.held)
                    report_mismatch("held_command", longint'(result_ch.held_command),
                                    longint'(want.held));
                if (result_ch.motor_urad !== want.motor)
                    report_mismatch("motor_urad", longint'(result_ch.motor_urad),
                                    longint'(want.motor));
                if (result_ch.stall_locked !== want.locked)
                    report_mismatch("stall_locked", longint'(result_ch.stall_locked),
                                    longint'(want.locked));
            end
            beats_checked++;
        end
    end

    // hard stop well past the slowest legal run
    initial
    begin : watchdog
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        int phase_end;
        int wait_count;
        // every block input known from time zero
        rst_n                   = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        sample_ch.valid         = 1'b0;
        sample_ch.commanded_pos = '0;
        sample_ch.measured_pos  = '0;
        result_ch.ready         = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values in effect: zero beat, range corners, one stalled tick
        add_typed(0, 0, 0, '0, 1'b0);
        add_tick(POS_MAX, POS_MAX);
        add_tick(POS_MIN, POS_MIN);
        add_tick(POS_MAX, POS_MIN);
        // short lock: two stalled ticks, tight thresholds
        add_cfg(REG_STALL_TICKS, 2);
        add_cfg(REG_RELEASE_THR, 100);
        add_cfg(REG_ERROR_THR, 10);
        add_cfg(REG_MOTION_THR, 5);
        add_tick(1000, 0);
        add_tick(1000, 2);
        // lock tick holds this measurement
        add_tick(1000, 3);
        // command exactly at the release threshold stays held
        add_tick(103, 3);
        add_tick(50, 3);
        // one past releases; this tick would stall but is not counted
        add_tick(104, 3);
        add_tick(1000, 3);
        add_tick(1000, 3);
        // gain extremes with the command passing through
        add_cfg(REG_MOTOR_GAIN, '0);
        add_typed(POS_MAX, POS_MAX, POS_MAX, '0, 1'b0);
        add_cfg(REG_MOTOR_GAIN, 32'h7fff_ffff);
        add_typed(POS_MAX, POS_MAX, POS_MAX, MOTOR_MAX, 1'b0);
        add_typed(POS_MIN, POS_MIN, POS_MIN, MOTOR_MIN, 1'b0);
        add_cfg(REG_MOTOR_GAIN, 32'h8000_0000);
        add_typed(POS_MIN, POS_MIN, POS_MIN, MOTOR_MAX, 1'b0);
        add_typed(POS_MAX, POS_MAX, POS_MAX, MOTOR_MIN, 1'b0);
        add_tick(1, 1);
        // half gain: rounding ties go toward plus infinity
        add_cfg(REG_MOTOR_GAIN, 32'h0000_8000);
        add_tick(1, 1);
        add_tick(-1, -1);
        // zero stall ticks locks on the first stalled tick
        add_cfg(REG_STALL_TICKS, 0);
        add_cfg(REG_ERROR_THR, 0);
        add_cfg(REG_MOTION_THR, 32'h007f_ffff);
        add_tick(1, 0);
        add_typed(POS_MIN, POS_MAX, 0, '0, 1'b1);

        foreach (plan_rows[i])
        begin
            if (plan_rows[i].is_cfg)
                write_reg(plan_rows[i].reg_idx, plan_rows[i].value);
            else
                send_tick(plan_rows[i].cmd, plan_rows[i].meas, plan_rows[i].typed,
                          plan_rows[i].want);
        end

        // random phases, each with its own register setting
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_ERROR_THR, DATA_BITS'(ERROR_THR_RST));
                    write_reg(REG_MOTION_THR, DATA_BITS'(MOTION_THR_RST));
                    write_reg(REG_RELEASE_THR, DATA_BITS'(RELEASE_THR_RST));
                    write_reg(REG_STALL_TICKS, DATA_BITS'(STALL_TICKS_RST));
                    write_reg(REG_MOTOR_GAIN, MOTOR_GAIN_RST);
                end
                2:
                begin
                    // lowest thresholds, widest motion window
                    write_reg(REG_ERROR_THR, 0);
                    write_reg(REG_MOTION_THR, 32'h007f_ffff);
                    write_reg(REG_RELEASE_THR, 0);
                    write_reg(REG_STALL_TICKS, 1);
                    write_reg(REG_MOTOR_GAIN, 32'h7fff_ffff);
                end
                3:
                begin
                    // highest error and release thresholds, zero motion threshold, longest lock delay
                    write_reg(REG_ERROR_THR, 32'h007f_ffff);
                    write_reg(REG_MOTION_THR, 0);
                    write_reg(REG_RELEASE_THR, 32'h007f_ffff);
                    write_reg(REG_STALL_TICKS, 32'h0000_ffff);
                    write_reg(REG_MOTOR_GAIN, 32'h8000_0000);
                end
                4:
                begin
                    write_reg(REG_ERROR_THR, $urandom_range(0, 3000));
                    write_reg(REG_MOTION_THR, $urandom_range(1, 300));
                    write_reg(REG_RELEASE_THR, $urandom_range(0, 3000));
                    write_reg(REG_STALL_TICKS, 0);
                    write_reg(REG_MOTOR_GAIN, $urandom());
                end
                5:
                begin
                    // full-width writes, upper bits dropped by the registers
                    write_reg(REG_ERROR_THR, $urandom());
                    write_reg(REG_MOTION_THR, $urandom());
                    write_reg(REG_RELEASE_THR, $urandom());
                    write_reg(REG_STALL_TICKS, $urandom());
                    write_reg(REG_MOTOR_GAIN, $urandom());
                end
                default:
                begin
                    write_reg(REG_ERROR_THR, $urandom_range(0, 5000));
                    write_reg(REG_MOTION_THR, $urandom_range(1, 500));
                    write_reg(REG_RELEASE_THR, $urandom_range(0, 10000));
                    write_reg(REG_STALL_TICKS, $urandom_range(1, 6));
                    write_reg(REG_MOTOR_GAIN, $urandom());
                end
            endcase
            // result side holds off while samples keep coming, so the input backs up
            if (phase == 1)
                long_hold_req = 1'b1;
            // last phase runs with no idling on either side
            if (phase == NUM_PHASES - 1)
                no_idle = 1'b1;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                run_episode();
        end

        // drain, with a limit of its own
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        wait_count = 0;
        while (pending_ticks.size() != 0 && wait_count < END_WAIT_LIMIT)
        begin
            @(posedge clk);
            wait_count++;
        end
        if (pending_ticks.size() != 0)
            report_mismatch("beats never returned", longint'(pending_ticks.size()), 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
rtl/gsl_pkg.sv
rtl/gsl_sample_if.sv
rtl/gsl_result_if.sv
rtl/gsl_lock_core.sv
rtl/gripper_stall_lock.sv
test/tb.sv
